### hdl/commit_header_block_detector_core_defines.svh
// assertion helpers for the commit header detector
`ifndef COMMIT_HEADER_BLOCK_DETECTOR_CORE_DEFINES_SVH
`define COMMIT_HEADER_BLOCK_DETECTOR_CORE_DEFINES_SVH

// same-cycle implication, checked outside reset
`define CHBD_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, checked outside reset
`define CHBD_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

### hdl/chbd_pkg.sv
package chbd_pkg;

  localparam int unsigned BLOCK_BYTES_DEF = 512;
  localparam int unsigned CNT_W = 40;
  localparam logic [CNT_W-1:0] CNT_MAX = {CNT_W{1'b1}};

  localparam int unsigned IN_DATA_W = 8;
  localparam int unsigned OUT_DATA_W = 88;

  // offsets that matter in the header line
  localparam int unsigned LEAD_LEN = 7;
  localparam int unsigned SPACE_OFF = 47;

  typedef enum logic [2:0] {
    PH_PREFIX  = 3'd0,
    PH_SCAN    = 3'd1,
    PH_TAIL    = 3'd2,
    PH_MATCHED = 3'd3,
    PH_FAILED  = 3'd4
  } phase_t;

  // "commit "
  function automatic logic [7:0] lead_char(input logic [2:0] idx);
    logic [7:0] c;
    case (idx)
      3'd0:    c = 8'h63;
      3'd1:    c = 8'h6f;
      3'd2:    c = 8'h6d;
      3'd3:    c = 8'h6d;
      3'd4:    c = 8'h69;
      3'd5:    c = 8'h74;
      3'd6:    c = 8'h20;
      default: c = 8'h00;
    endcase
    return c;
  endfunction

  // "Author:"
  function automatic logic [7:0] author_char(input logic [2:0] idx);
    logic [7:0] c;
    case (idx)
      3'd0:    c = 8'h41;
      3'd1:    c = 8'h75;
      3'd2:    c = 8'h74;
      3'd3:    c = 8'h68;
      3'd4:    c = 8'h6f;
      3'd5:    c = 8'h72;
      3'd6:    c = 8'h3a;
      default: c = 8'h00;
    endcase
    return c;
  endfunction

  // "Merge:"
  function automatic logic [7:0] merge_char(input logic [2:0] idx);
    logic [7:0] c;
    case (idx)
      3'd0:    c = 8'h4d;
      3'd1:    c = 8'h65;
      3'd2:    c = 8'h72;
      3'd3:    c = 8'h67;
      3'd4:    c = 8'h65;
      3'd5:    c = 8'h3a;
      default: c = 8'h00;
    endcase
    return c;
  endfunction

  function automatic logic hex_or_space(input logic [7:0] b);
    return (b >= 8'h30 && b <= 8'h39) || (b >= 8'h61 && b <= 8'h66) ||
           (b >= 8'h41 && b <= 8'h46) || (b == 8'h20);
  endfunction

endpackage

### hdl/commit_header_block_detector_core.sv
// the verdict is registered and shows on out_* in the cycle after the last beat of its block
// throughput: one byte beat per cycle, sustained, while out_tready keeps up
// the verdict sits in a single output register; the next block streams in behind it
// reset: synchronous on rst_n low; block state, both counters and out_tvalid clear
`include "commit_header_block_detector_core_defines.svh"

module commit_header_block_detector_core
  import chbd_pkg::*;
#(
  parameter int unsigned BLOCK_BYTES = BLOCK_BYTES_DEF
) (
  input  logic                  clk,
  input  logic                  rst_n,
  // byte stream
  input  logic                  in_tvalid,
  output logic                  in_tready,
  input  logic [IN_DATA_W-1:0]  in_tdata,   // [7:0] data_byte
  input  logic                  in_tlast,   // block_end
  // one verdict per block
  output logic                  out_tvalid,
  input  logic                  out_tready,
  output logic [OUT_DATA_W-1:0] out_tdata   // [0] is_match, [40:1] block_number,
                                            // [80:41] matches_found, [87:81] zero
);

  // offset counter just wide enough to hold BLOCK_BYTES itself
  localparam int unsigned OFF_W = $clog2(BLOCK_BYTES + 1);
  localparam logic [OFF_W-1:0] OFF_LIM   = OFF_W'(BLOCK_BYTES);
  localparam logic [OFF_W-1:0] OFF_LEAD  = OFF_W'(LEAD_LEN);
  localparam logic [OFF_W-1:0] OFF_SPACE = OFF_W'(SPACE_OFF);

  // per-block scan state
  logic [OFF_W-1:0] byte_offset_r, byte_offset_nxt;
  phase_t           phase_r, phase_nxt;
  logic [2:0]       tail_offset_r, tail_offset_nxt;
  logic [1:0]       alive_r, alive_nxt;       // bit0 author, bit1 merge

  // running counters
  logic [CNT_W-1:0] block_cnt_r, block_cnt_nxt;
  logic [CNT_W-1:0] match_cnt_r, match_cnt_nxt;

  // output register
  logic             out_valid_r, out_valid_nxt;
  logic             out_match_r, out_match_nxt;
  logic [CNT_W-1:0] out_block_r, out_block_nxt;
  logic [CNT_W-1:0] out_count_r, out_count_nxt;

  logic       in_beat;
  logic [7:0] b;
  logic       in_window;
  // scan result for the current byte, before end-of-block handling
  phase_t     ph_scan;
  logic [2:0] tail_scan;
  logic [1:0] alive_scan;
  logic       keep_author, keep_merge;
  logic       hit;

  // the output register frees up the same cycle it is drained
  assign in_tready = !out_valid_r || out_tready;
  assign in_beat   = in_tvalid && in_tready;
  assign b         = in_tdata[7:0];
  assign in_window = byte_offset_r < OFF_LIM;

  // header matcher: one byte a beat, bytes past the block size are ignored
  always_comb begin
    ph_scan     = phase_r;
    tail_scan   = tail_offset_r;
    alive_scan  = alive_r;
    keep_author = 1'b0;
    keep_merge  = 1'b0;
    if (in_window) begin
      case (phase_r)
        PH_PREFIX: begin
          if (byte_offset_r < OFF_LEAD) begin
            if (b != lead_char(byte_offset_r[2:0])) begin
              ph_scan = PH_FAILED;
            end
          end else if (byte_offset_r == OFF_SPACE) begin
            ph_scan = (b == 8'h20) ? PH_SCAN : PH_FAILED;
          end
        end
        PH_SCAN: begin
          if (b == 8'h0a) begin
            ph_scan    = PH_TAIL;
            tail_scan  = 3'd0;
            alive_scan = 2'b11;
          end else if (!hex_or_space(b)) begin
            ph_scan = PH_FAILED;
          end
        end
        PH_TAIL: begin
          // both candidate keywords are tracked in parallel
          keep_author = alive_r[0] && (tail_offset_r != 3'd7) &&
                        (b == author_char(tail_offset_r));
          keep_merge  = alive_r[1] && (tail_offset_r < 3'd6) &&
                        (b == merge_char(tail_offset_r));
          alive_scan  = {keep_merge, keep_author};
          if ((keep_author && tail_offset_r == 3'd6) ||
              (keep_merge && tail_offset_r == 3'd5)) begin
            ph_scan = PH_MATCHED;
          end else if (!keep_author && !keep_merge) begin
            ph_scan = PH_FAILED;
          end
          tail_scan = tail_offset_r + 3'd1;
        end
        default: begin
          // matched or failed: the rest of the block is ignored
        end
      endcase
    end
  end

  // state update, verdict and counters
  always_comb begin
    byte_offset_nxt = byte_offset_r;
    phase_nxt       = phase_r;
    tail_offset_nxt = tail_offset_r;
    alive_nxt       = alive_r;
    block_cnt_nxt   = block_cnt_r;
    match_cnt_nxt   = match_cnt_r;
    out_valid_nxt   = out_valid_r && !out_tready;
    out_match_nxt   = out_match_r;
    out_block_nxt   = out_block_r;
    out_count_nxt   = out_count_r;
    hit             = (ph_scan == PH_MATCHED);

    if (in_beat) begin
      if (in_tlast) begin
        // count includes this block, both counters stick at all ones
        if (hit && match_cnt_r != CNT_MAX) begin
          match_cnt_nxt = match_cnt_r + CNT_W'(1);
        end
        if (block_cnt_r != CNT_MAX) begin
          block_cnt_nxt = block_cnt_r + CNT_W'(1);
        end
        out_valid_nxt   = 1'b1;
        out_match_nxt   = hit;
        out_block_nxt   = block_cnt_r;
        out_count_nxt   = match_cnt_nxt;
        byte_offset_nxt = '0;
        phase_nxt       = PH_PREFIX;
        tail_offset_nxt = 3'd0;
        alive_nxt       = 2'b11;
      end else begin
        phase_nxt       = ph_scan;
        tail_offset_nxt = tail_scan;
        alive_nxt       = alive_scan;
        if (in_window) begin
          byte_offset_nxt = byte_offset_r + OFF_W'(1);
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      byte_offset_r <= '0;
      phase_r       <= PH_PREFIX;
      tail_offset_r <= 3'd0;
      alive_r       <= 2'b11;
      block_cnt_r   <= '0;
      match_cnt_r   <= '0;
      out_valid_r   <= 1'b0;
    end else begin
      byte_offset_r <= byte_offset_nxt;
      phase_r       <= phase_nxt;
      tail_offset_r <= tail_offset_nxt;
      alive_r       <= alive_nxt;
      block_cnt_r   <= block_cnt_nxt;
      match_cnt_r   <= match_cnt_nxt;
      out_valid_r   <= out_valid_nxt;
    end
  end

  // payload needs no reset, it is only read with out_tvalid
  always_ff @(posedge clk) begin
    out_match_r <= out_match_nxt;
    out_block_r <= out_block_nxt;
    out_count_r <= out_count_nxt;
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {7'd0, out_count_r, out_block_r, out_match_r};

  // the line after the newline can only be reached once offset 47 is through
  `CHBD_ASSERT_NOW(a_tail_after_space, phase_r == PH_TAIL, byte_offset_r > OFF_SPACE, "tail phase entered too early")

  // while in the tail at least one keyword must still be possible
  `CHBD_ASSERT_NOW(a_tail_alive, phase_r == PH_TAIL, alive_r != 2'b00, "tail phase with no live keyword")

  // a matching verdict always carries a non-zero running count
  `CHBD_ASSERT_NOW(a_match_counted, out_valid_r && out_match_r, out_count_r != '0, "match verdict with zero count")

  // each finished block advances the block counter by one until it saturates
  `CHBD_ASSERT_NEXT(a_block_step, in_beat && in_tlast && block_cnt_r != CNT_MAX, block_cnt_r == $past(block_cnt_r) + CNT_W'(1), "block counter did not advance")

endmodule

### sim/commit_header_block_detector_core_tb.sv
`timescale 1ns / 1ps

module commit_header_block_detector_core_tb
  import chbd_pkg::*;
();

  localparam int unsigned BLOCK_BYTES = BLOCK_BYTES_DEF;
  localparam int unsigned CYCLE_LIMIT = 200000;
  localparam int unsigned HOLD_CYCLES = 300;
  localparam int unsigned IDLE_PCT = 34;

  // header texts, first character in the top byte
  localparam logic [8*7-1:0]  LEAD_TXT   = "commit ";
  localparam logic [8*7-1:0]  AUTHOR_TXT = "Author:";
  localparam logic [8*6-1:0]  MERGE_TXT  = "Merge:";
  localparam logic [8*23-1:0] HEX_SET    = "0123456789abcdefABCDEF ";
  localparam logic [7:0]      CH_NL      = 8'h0a;
  localparam logic [7:0]      CH_SP      = 8'h20;
  localparam logic [7:0]      CH_BAD     = 8'h21;

  typedef struct packed {
    logic             hit;
    logic [CNT_W-1:0] idx;
    logic [CNT_W-1:0] total;
  } verdict_t;

  logic                  clk = 1'b0;
  logic                  rst_n = 1'b0;
  logic                  in_tvalid = 1'b0;
  logic                  in_tready;
  logic [IN_DATA_W-1:0]  in_tdata = '0;
  logic                  in_tlast = 1'b0;
  logic                  out_tvalid;
  logic                  out_tready = 1'b0;
  logic [OUT_DATA_W-1:0] out_tdata;

  commit_header_block_detector_core dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tlast   (in_tlast),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata)
  );

  // verdict fields as the block packs them
  wire             got_hit   = out_tdata[0];
  wire [CNT_W-1:0] got_idx   = out_tdata[CNT_W:1];
  wire [CNT_W-1:0] got_total = out_tdata[2*CNT_W:CNT_W+1];

  // scanner state of the header predictor
  int unsigned      scan_pos = 0;
  phase_t           scan_phase = PH_PREFIX;
  logic [2:0]       line_pos = '0;
  logic [1:0]       tail_alive = 2'b11;
  logic [CNT_W-1:0] blocks_done = '0;
  logic [CNT_W-1:0] headers_found = '0;

  verdict_t    verdicts_due [$];
  logic [7:0]  blk_bytes [$];
  int unsigned beats_sent = 0;
  int unsigned blocks_sent = 0;
  int unsigned faults = 0;
  int unsigned cycles = 0;
  int unsigned hold_left = 0;
  bit          hold_request = 1'b0;
  bit          steady = 1'b0;

  initial begin
    forever #5 clk = ~clk;
  end

  // run limit
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("commit_header_block_detector_core: mismatch");
      $finish;
    end
  end

  function automatic logic hex_or_blank(input logic [7:0] b);
    return (b >= "0" && b <= "9") || (b >= "a" && b <= "f") ||
           (b >= "A" && b <= "F") || b == CH_SP;
  endfunction

  // predict one accepted beat; a block end queues its verdict
  function automatic void scan_beat(input logic [7:0] b, input logic last);
    logic [2:0] t;
    verdict_t   v;
    if (scan_pos < BLOCK_BYTES) begin
      case (scan_phase)
        PH_PREFIX: begin
          if (scan_pos < LEAD_LEN) begin
            if (b != LEAD_TXT[8*(LEAD_LEN-1-scan_pos) +: 8]) scan_phase = PH_FAILED;
          end else if (scan_pos == SPACE_OFF) begin
            scan_phase = (b == CH_SP) ? PH_SCAN : PH_FAILED;
          end
        end
        PH_SCAN: begin
          if (b == CH_NL) begin
            scan_phase = PH_TAIL;
            line_pos = '0;
            tail_alive = 2'b11;
          end else if (!hex_or_blank(b)) begin
            scan_phase = PH_FAILED;
          end
        end
        PH_TAIL: begin
          t = line_pos;
          // either keyword may still be on the line; drop each as it diverges
          if (tail_alive[0] && (t >= 7 || b != AUTHOR_TXT[8*(6-t) +: 8])) tail_alive[0] = 1'b0;
          if (tail_alive[1] && (t >= 6 || b != MERGE_TXT[8*(5-t) +: 8])) tail_alive[1] = 1'b0;
          if ((tail_alive[0] && t == 3'd6) || (tail_alive[1] && t == 3'd5)) begin
            scan_phase = PH_MATCHED;
          end else if (tail_alive == 2'b00) begin
            scan_phase = PH_FAILED;
          end
          line_pos = t + 3'd1;
        end
        default: ;
      endcase
      scan_pos++;
    end
    if (last) begin
      v.hit = (scan_phase == PH_MATCHED);
      if (v.hit && headers_found != CNT_MAX) headers_found = headers_found + 1'b1;
      v.idx = blocks_done;
      v.total = headers_found;
      verdicts_due.push_back(v);
      if (blocks_done != CNT_MAX) blocks_done = blocks_done + 1'b1;
      scan_pos = 0;
      scan_phase = PH_PREFIX;
      line_pos = '0;
      tail_alive = 2'b11;
    end
  endfunction

  // receiver: checks each verdict and paces out_tready
  always @(posedge clk) begin
    if (rst_n && out_tvalid && out_tready) begin
      if (verdicts_due.size() == 0) begin
        $display("%0t: unexpected verdict expected none got %0h/%0h/%0h",
                 $time, got_hit, got_idx, got_total);
        faults++;
      end else begin
        if (got_hit !== verdicts_due[0].hit) begin
          $display("%0t: is_match expected %0h got %0h", $time,
                   verdicts_due[0].hit, got_hit);
          faults++;
        end
        if (got_idx !== verdicts_due[0].idx) begin
          $display("%0t: block_number expected %0h got %0h", $time,
                   verdicts_due[0].idx, got_idx);
          faults++;
        end
        if (got_total !== verdicts_due[0].total) begin
          $display("%0t: matches_found expected %0h got %0h", $time,
                   verdicts_due[0].total, got_total);
          faults++;
        end
        void'(verdicts_due.pop_front());
      end
    end
    // a long hold lets the output register fill and back up the byte stream
    if (hold_left > 0) begin
      hold_left <= hold_left - 1;
      out_tready <= 1'b0;
    end else if (hold_request) begin
      hold_request <= 1'b0;
      hold_left <= HOLD_CYCLES;
      out_tready <= 1'b0;
    end else begin
      out_tready <= rst_n && (steady || $urandom_range(0, 99) >= IDLE_PCT);
    end
  end

  // offer one byte beat, with random gaps, and predict it once accepted
  task automatic send_beat(input logic [7:0] b, input logic last);
    while (!steady && $urandom_range(0, 99) < IDLE_PCT) begin
      in_tvalid <= 1'b0;
      @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata <= b;
    in_tlast <= last;
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    scan_beat(b, last);
    beats_sent++;
  endtask

  task automatic send_block();
    int i;
    for (i = 0; i < blk_bytes.size(); i++) begin
      send_beat(blk_bytes[i], i == blk_bytes.size() - 1);
    end
    blocks_sent++;
  endtask

  // well-formed header: lead, 40 free bytes, space, hex run, newline, keyword, trailer
  function automatic void build_header(input int hex_run, input bit use_merge,
                                       input int trail);
    int i;
    blk_bytes.delete();
    for (i = 0; i < LEAD_LEN; i++) blk_bytes.push_back(LEAD_TXT[8*(LEAD_LEN-1-i) +: 8]);
    for (i = 0; i < 40; i++) blk_bytes.push_back($urandom_range(0, 255));
    blk_bytes.push_back(CH_SP);
    for (i = 0; i < hex_run; i++) blk_bytes.push_back(HEX_SET[8*(22-$urandom_range(0, 22)) +: 8]);
    blk_bytes.push_back(CH_NL);
    if (use_merge) begin
      for (i = 0; i < 6; i++) blk_bytes.push_back(MERGE_TXT[8*(5-i) +: 8]);
    end else begin
      for (i = 0; i < 7; i++) blk_bytes.push_back(AUTHOR_TXT[8*(6-i) +: 8]);
    end
    for (i = 0; i < trail; i++) blk_bytes.push_back($urandom_range(0, 255));
  endfunction

  function automatic void build_noise(input int len);
    int i;
    blk_bytes.delete();
    for (i = 0; i < len; i++) blk_bytes.push_back($urandom_range(0, 255));
  endfunction

  function automatic void cut_to(input int len);
    while (blk_bytes.size() > len) void'(blk_bytes.pop_back());
  endfunction

  // mostly headers with random content, the rest broken or plain noise
  function automatic void build_random_block();
    int pick;
    pick = $urandom_range(0, 99);
    build_header($urandom_range(0, 24), $urandom_range(0, 1), $urandom_range(0, 8));
    if (pick < 55) begin
    end else if (pick < 75) begin
      blk_bytes[$urandom_range(0, blk_bytes.size() - 1)] = $urandom_range(0, 255);
    end else if (pick < 85) begin
      cut_to($urandom_range(1, blk_bytes.size() - 1));
    end else begin
      build_noise($urandom_range(1, 24));
    end
  endfunction

  // both keywords, empty hex run, bytes after a complete header, tail faults
  task automatic test_good_headers();
    build_header(6, 1'b0, 0);  send_block();
    build_header(3, 1'b1, 0);  send_block();
    build_header(0, 1'b0, 0);  send_block();
    build_header(2, 1'b1, 20); send_block();
    // keyword diverging at its last character, then Merge: diverging partway through
    build_header(4, 1'b0, 0);
    blk_bytes[blk_bytes.size() - 1] = CH_BAD;
    send_block();
    build_header(4, 1'b1, 0);
    blk_bytes[blk_bytes.size() - 4] = CH_BAD;
    send_block();
    // neither keyword at the start of the line
    build_header(1, 1'b0, 3);
    blk_bytes[50] = "X";
    send_block();
  endtask

  // faults in the fixed part and the hex run, and blocks that end too early
  task automatic test_broken_headers();
    build_header(5, 1'b0, 0);
    blk_bytes[3] = "M";
    send_block();
    build_header(5, 1'b0, 0);
    blk_bytes[SPACE_OFF] = "x";
    send_block();
    build_header(5, 1'b1, 0);
    blk_bytes[50] = "g";
    send_block();
    build_header(8, 1'b0, 0);
    cut_to(30);
    send_block();
    build_header(8, 1'b0, 0);
    cut_to(blk_bytes.size() - 1);
    send_block();
    build_noise(1);
    blk_bytes[0] = LEAD_TXT[8*6 +: 8];
    send_block();
    build_noise(1);
    blk_bytes[0] = 8'hff;
    send_block();
    build_noise(3);
    blk_bytes[0] = 8'h00;
    blk_bytes[1] = 8'hff;
    blk_bytes[2] = 8'h00;
    send_block();
  endtask

  // keyword ending on the last counted byte with bytes past the limit,
  // then a keyword ending one byte too late
  task automatic test_block_limit();
    build_header(BLOCK_BYTES - 55, 1'b1, 2); send_block();
    build_header(BLOCK_BYTES - 55, 1'b0, 0); send_block();
  endtask

  // stream with no gaps on either side
  task automatic test_back_to_back();
    int n;
    steady = 1'b1;
    for (n = 0; n < 5; n++) begin
      build_random_block();
      send_block();
    end
    steady = 1'b0;
  endtask

  // receiver holds off while short blocks keep coming
  task automatic test_output_hold();
    int n;
    hold_request = 1'b1;
    for (n = 0; n < 12; n++) begin
      build_noise($urandom_range(1, 4));
      send_block();
    end
  endtask

  task automatic test_random_blocks();
    int unsigned first_beat;
    int unsigned first_block;
    first_beat = beats_sent;
    first_block = blocks_sent;
    while (beats_sent - first_beat < 200 || blocks_sent - first_block < 4) begin
      build_random_block();
      send_block();
    end
  endtask

  initial begin
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_good_headers();
    test_broken_headers();
    test_block_limit();
    test_back_to_back();
    test_output_hold();
    test_random_blocks();
    in_tvalid <= 1'b0;
    while (verdicts_due.size() != 0) @(posedge clk);
    repeat (10) @(posedge clk);
    if (faults == 0) begin
      $display("commit_header_block_detector_core: match");
    end else begin
      $display("commit_header_block_detector_core: mismatch");
    end
    $finish;
  end

endmodule

### commit_header_block_detector_core.f
+incdir+hdl
hdl/chbd_pkg.sv
hdl/commit_header_block_detector_core.sv
sim/commit_header_block_detector_core_tb.sv
